### rtl/core/bilinear_block_homogeneity_test_defines.svh
// Assertion helpers used by the bound checker module.
`ifndef BILINEAR_BLOCK_HOMOGENEITY_TEST_DEFINES_SVH
`define BILINEAR_BLOCK_HOMOGENEITY_TEST_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define BBHT_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbht: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define BBHT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbht: next-cycle check failed");

`endif

### rtl/core/bbht_pkg.sv
`default_nettype none

package bbht_pkg;

   localparam int BLOCK_SIDE  = 64;
   localparam int STORE_DEPTH = BLOCK_SIDE * BLOCK_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int PIX_W   = 8;
   localparam int SPAN_W  = 6;
   localparam int THR_W   = 12;
   localparam int COUNT_W = 13;
   localparam int DEN_W   = 2 * SPAN_W;
   localparam int STEP_W  = 16;
   localparam int NUM_W   = 22;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 12'd160;

   // corner codes, top-left first in raster order
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BL = 2'd2;
   localparam logic [1:0] CORNER_BR = 2'd3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CORNER,
      ST_SETUP0,
      ST_SETUP1,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       corner_rd;
      logic [1:0] corner_sel;
      logic       setup0;
      logic       setup1;
      logic       issue;
      logic       row_end;
   } eval_ctrl_type;

endpackage

`default_nettype wire

### rtl/core/bbht_pixel_ram.sv
`default_nettype none

module bbht_pixel_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bbht_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [bbht_pkg::PIX_W-1:0]    wr_data,
   input  logic [bbht_pkg::ADDR_W-1:0]   rd_addr,
   output logic [bbht_pkg::PIX_W-1:0]    rd_data
);
   import bbht_pkg::*;

   logic [PIX_W-1:0] store_mem [STORE_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/bbht_eval.sv
`default_nettype none

module bbht_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  bbht_pkg::eval_ctrl_type       ctrl,
   input  logic [bbht_pkg::SPAN_W-1:0]   span_x,
   input  logic [bbht_pkg::SPAN_W-1:0]   span_y,
   input  logic [bbht_pkg::THR_W-1:0]    threshold,
   input  logic [bbht_pkg::PIX_W-1:0]    rd_data,
   output logic                          split
);
   import bbht_pkg::*;

   localparam int PROD_W = PIX_W + DEN_W;
   localparam int TDEN_W = THR_W + DEN_W;
   localparam int DIFF_W = NUM_W + 1;
   localparam int CMP_W  = DIFF_W + 4;

   logic [PIX_W-1:0] g_tl_ff, g_tr_ff, g_bl_ff, g_br_ff;
   logic             corner_vld_ff;
   logic [1:0]       corner_sel_ff;

   logic [SPAN_W-1:0] ex, ey;
   logic [DEN_W-1:0]  den;
   logic signed [PIX_W:0]    d_tl_bl, d_tl_tr, d_tr_br;
   logic signed [STEP_W-1:0] row_step, col_init, col_delta;

   logic [DEN_W-1:0]         den_ff;
   logic [TDEN_W-1:0]        tden_ff;
   logic signed [STEP_W-1:0] row_step_ff, col_ff, col_delta_ff;
   logic signed [NUM_W-1:0]  row_ff, num_ff, row_next;

   logic [PROD_W-1:0] base, prod;
   logic [TDEN_W-1:0] tden;

   logic                    iss_d1_ff, v2_ff, v3_ff;
   logic signed [NUM_W-1:0] num_d1_ff, num_d2_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [DIFF_W-1:0]       mag;
   logic [CMP_W-1:0]        scaled;
   logic                    split_ff;

   // a zero span degenerates to one point with unit weight on that axis
   assign ex  = (span_x == '0) ? SPAN_W'(1) : span_x;
   assign ey  = (span_y == '0) ? SPAN_W'(1) : span_y;
   assign den = ex * ey;

   assign d_tl_bl   = $signed({1'b0, g_bl_ff}) - $signed({1'b0, g_tl_ff});
   assign d_tl_tr   = $signed({1'b0, g_tr_ff}) - $signed({1'b0, g_tl_ff});
   assign d_tr_br   = $signed({1'b0, g_br_ff}) - $signed({1'b0, g_tr_ff});
   assign row_step  = d_tl_bl * $signed({1'b0, ex});
   assign col_init  = d_tl_tr * $signed({1'b0, ey});
   assign col_delta = d_tr_br - d_tl_bl;

   assign base     = g_tl_ff * den_ff;
   assign tden     = threshold * den_ff;
   assign prod     = rd_data * den_ff;
   assign row_next = row_ff + row_step_ff;

   assign mag    = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
   assign scaled = {mag, 4'b0000};

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_vld_ff <= 1'b0;
         iss_d1_ff     <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         split_ff      <= 1'b0;
      end else begin
         corner_vld_ff <= ctrl.corner_rd;
         iss_d1_ff     <= ctrl.issue;
         v2_ff         <= iss_d1_ff;
         v3_ff         <= v2_ff;
         if (ctrl.setup0) begin
            split_ff <= 1'b0;
         end else if (v3_ff && (scaled > CMP_W'(tden_ff))) begin
            split_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      corner_sel_ff <= ctrl.corner_sel;
      if (corner_vld_ff) begin
         unique case (corner_sel_ff)
            CORNER_TL: g_tl_ff <= rd_data;
            CORNER_TR: g_tr_ff <= rd_data;
            CORNER_BL: g_bl_ff <= rd_data;
            CORNER_BR: g_br_ff <= rd_data;
            default:   g_tl_ff <= rd_data;
         endcase
      end

      if (ctrl.setup0) begin
         den_ff       <= den;
         row_step_ff  <= row_step;
         col_ff       <= col_init;
         col_delta_ff <= col_delta;
      end

      if (ctrl.setup1) begin
         row_ff  <= $signed(NUM_W'(base));
         num_ff  <= $signed(NUM_W'(base));
         tden_ff <= tden;
      end

      // walk the estimate across the row, restart from the next row base
      if (ctrl.issue) begin
         num_d1_ff <= num_ff;
         if (ctrl.row_end) begin
            row_ff <= row_next;
            num_ff <= row_next;
            col_ff <= col_ff + col_delta_ff;
         end else begin
            num_ff <= num_ff + col_ff;
         end
      end

      if (iss_d1_ff) begin
         prod_ff   <= prod;
         num_d2_ff <= num_d1_ff;
      end

      if (v2_ff) begin
         diff_ff <= num_d2_ff - $signed(DIFF_W'(prod_ff));
      end
   end

   assign split = split_ff;

endmodule

`default_nettype wire

### rtl/core/bilinear_block_homogeneity_test.sv
// Block homogeneity test by bilinear interpolation of the four corners.
// Input channel (req_*): one grey pixel per item in raster order, with the
// block spans and a last flag; the spans are taken from the first item.
// Result channel (rsp_*): one item per block, sent after the item marked
// last: needs_split, and count_error when the pixel count does not match
// the spans (needs_split is then 0). Config port (csr_*): 12-bit threshold,
// unsigned 8.4 grey levels, to be written by the user only while the
// block is idle; the block itself does not enforce this. Timing: pixels
// load at one per cycle into the pixel RAM. After the last one, the
// corners are read, the interpolation is set up, then one RAM read per
// pixel scans the block through the single read port of the pixel RAM,
// the compare pipeline drains and the result enters the output register.
// A count error skips the scan and goes straight to the result.
// Reset clears the load counter, spans and state and sets the threshold
// to 160; the pixel RAM is not cleared. A stalled result waits in the
// output register while the next block loads; req_stall stays high from
// the item marked last until the result enters the output register.
`default_nettype none

module bilinear_block_homogeneity_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bbht_pkg::PIX_W-1:0]    req_pixel,
   input  logic [bbht_pkg::SPAN_W-1:0]   req_span_x,
   input  logic [bbht_pkg::SPAN_W-1:0]   req_span_y,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_needs_split,
   output logic                          rsp_count_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbht_pkg::THR_W-1:0]    csr_threshold
);
   import bbht_pkg::*;

   localparam logic [2:0] CORNER_STEPS = 3'd4;
   localparam logic [1:0] DRAIN_LAST   = 2'd2;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] load_count_ff, load_count_in, count_inc, blk_n_ff, n_minus1;
   logic [SPAN_W-1:0]  span_x_ff, span_y_ff, sx_eff, sy_eff;
   logic [SPAN_W:0]    wx, wy;
   logic [2*SPAN_W+1:0] area;
   logic               err, err_ff;
   logic [THR_W-1:0]   threshold_ff;

   logic [2:0]         corner_cnt_ff;
   logic [1:0]         drain_ff;
   logic [SPAN_W-1:0]  x_ff, y_ff;
   logic [ADDR_W-1:0]  scan_addr_ff;
   logic               scan_end;

   logic               accept, out_free, rsp_load;
   logic               rsp_valid_ff, rsp_valid_in, rsp_needs_split_ff, rsp_count_error_ff;

   eval_ctrl_type      ctrl;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [PIX_W-1:0]   rd_data;
   logic               split;

   assign accept    = req_valid && !req_stall;
   assign sx_eff    = (load_count_ff == '0) ? req_span_x : span_x_ff;
   assign sy_eff    = (load_count_ff == '0) ? req_span_y : span_y_ff;
   assign count_inc = (load_count_ff == COUNT_MAX) ? load_count_ff
                                                   : load_count_ff + COUNT_W'(1);
   assign wx        = {1'b0, sx_eff} + (SPAN_W+1)'(1);
   assign wy        = {1'b0, sy_eff} + (SPAN_W+1)'(1);
   assign area      = wx * wy;
   assign err       = (count_inc != area) || (int'(wx) > BLOCK_SIDE)
                      || (int'(wy) > BLOCK_SIDE);

   assign load_count_in = (accept && req_last) ? '0
                          : (accept ? count_inc : load_count_ff);
   assign wr_en    = accept && (load_count_ff < STORE_DEPTH);
   assign n_minus1 = blk_n_ff - COUNT_W'(1);
   assign scan_end = (x_ff == span_x_ff) && (y_ff == span_y_ff);

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) begin
               state_in = err ? ST_DONE : ST_CORNER;
            end
         end
         ST_CORNER: begin
            if (corner_cnt_ff == CORNER_STEPS) begin
               state_in = ST_SETUP0;
            end
         end
         ST_SETUP0: state_in = ST_SETUP1;
         ST_SETUP1: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      rsp_load        = 1'b0;
      rd_addr         = '0;
      ctrl            = '0;
      ctrl.corner_sel = corner_cnt_ff[1:0];
      ctrl.row_end    = (x_ff == span_x_ff);
      unique case (state_ff)
         ST_LOAD: req_stall = 1'b0;
         ST_CORNER: begin
            ctrl.corner_rd = (corner_cnt_ff != CORNER_STEPS);
            unique case (corner_cnt_ff[1:0])
               CORNER_TL: rd_addr = '0;
               CORNER_TR: rd_addr = ADDR_W'(span_x_ff);
               CORNER_BL: rd_addr = ADDR_W'(n_minus1 - COUNT_W'(span_x_ff));
               CORNER_BR: rd_addr = ADDR_W'(n_minus1);
               default:   rd_addr = '0;
            endcase
         end
         ST_SETUP0: ctrl.setup0 = 1'b1;
         ST_SETUP1: ctrl.setup1 = 1'b1;
         ST_SCAN: begin
            ctrl.issue = 1'b1;
            rd_addr    = scan_addr_ff;
         end
         ST_DRAIN: ;
         ST_DONE:  rsp_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         span_x_ff     <= '0;
         span_y_ff     <= '0;
         threshold_ff  <= THRESHOLD_RESET;
         corner_cnt_ff <= '0;
         drain_ff      <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         scan_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_threshold;
         end
         // spans come from the first item of a block only
         if (accept && (load_count_ff == '0)) begin
            span_x_ff <= req_span_x;
            span_y_ff <= req_span_y;
         end
         corner_cnt_ff <= (state_ff == ST_CORNER) ? corner_cnt_ff + 3'd1 : '0;
         drain_ff      <= (state_ff == ST_DRAIN) ? drain_ff + 2'd1 : '0;
         if (state_ff == ST_SCAN) begin
            scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
            if (x_ff == span_x_ff) begin
               x_ff <= '0;
               y_ff <= y_ff + SPAN_W'(1);
            end else begin
               x_ff <= x_ff + SPAN_W'(1);
            end
         end else begin
            x_ff         <= '0;
            y_ff         <= '0;
            scan_addr_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         blk_n_ff <= count_inc;
         err_ff   <= err;
      end
      if (rsp_load) begin
         rsp_needs_split_ff <= split && !err_ff;
         rsp_count_error_ff <= err_ff;
      end
   end

   bbht_pixel_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(load_count_ff)),
      .wr_data (req_pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbht_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .span_x    (span_x_ff),
      .span_y    (span_y_ff),
      .threshold (threshold_ff),
      .rd_data   (rd_data),
      .split     (split)
   );

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_needs_split = rsp_needs_split_ff;
   assign rsp_count_error = rsp_count_error_ff;

endmodule

`default_nettype wire

### rtl/core/bbht_checker.sv
`default_nettype none
`include "bilinear_block_homogeneity_test_defines.svh"

module bbht_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_needs_split,
   input  logic                          rsp_count_error
);

   logic       req_take;
   logic       rsp_wait;
   logic [1:0] rsp_fields;

   assign req_take   = req_valid && !req_stall;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_fields = {rsp_needs_split, rsp_count_error};

   // stall the block input once the closing item is taken
   `BBHT_ASSERT_NEXT(a_stall_after_last, clock, reset, req_take && req_last, req_stall)

   // keep loading while a block is still open
   `BBHT_ASSERT_NEXT(a_open_after_pixel, clock, reset, req_take && !req_last, !req_stall)

   // a new answer only follows a closed input side
   `BBHT_ASSERT_SAME(a_rsp_after_close, clock, reset, $rose(rsp_valid), $past(req_stall))

   // a stalled answer holds
   `BBHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_fields))

endmodule

bind bilinear_block_homogeneity_test bbht_checker u_bbht_checker (.*);

`default_nettype wire

### tb/bbht_checker.sv
`timescale 1ns / 100ps

module bbht_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [bbht_pkg::PIX_W-1:0]    req_pixel,
   input  logic [bbht_pkg::SPAN_W-1:0]   req_span_x,
   input  logic [bbht_pkg::SPAN_W-1:0]   req_span_y,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_needs_split,
   input  logic                          rsp_count_error,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bbht_pkg::THR_W-1:0]    csr_threshold,
   output int                            mismatch_count,
   output int                            verdicts_pending
);

   typedef struct packed {
      logic needs_split;
      logic count_error;
   } verdict_type;

   verdict_type                  verdicts_due[$];
   logic [bbht_pkg::PIX_W-1:0]   pixel_copy [bbht_pkg::STORE_DEPTH];
   logic [bbht_pkg::COUNT_W-1:0] pixels_seen;
   logic [bbht_pkg::SPAN_W-1:0]  block_span_x;
   logic [bbht_pkg::SPAN_W-1:0]  block_span_y;
   logic [bbht_pkg::THR_W-1:0]   allowed_dev;

   initial begin
      mismatch_count = 0;
      verdicts_pending = 0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: bbht mismatch: %s", $time, what);
   endtask

   // Exact integer form of the check: scale both sides by the denominator.
   function automatic bit block_deviates();
      longint dx, dy, den, lim, g1, g2, g3, g4, num, diff, xi, yi;
      int sx, sy, w, n, stride;
      sx = int'(block_span_x);
      sy = int'(block_span_y);
      dx = sx;
      dy = sy;
      w = sx + 1;
      lim = longint'(allowed_dev);
      if (sx != 0 && sy != 0) begin
         g1 = pixel_copy[0];
         g2 = pixel_copy[sx];
         g3 = pixel_copy[sy * w];
         g4 = pixel_copy[sy * w + sx];
         den = dx * dy;
         for (int y = 0; y <= sy; y++) begin
            for (int x = 0; x <= sx; x++) begin
               xi = x;
               yi = y;
               num = g1 * (dx - xi) * (dy - yi) + g2 * xi * (dy - yi)
                   + g3 * (dx - xi) * yi + g4 * xi * yi;
               diff = 16 * num - 16 * longint'(pixel_copy[y * w + x]) * den;
               if (diff < 0) diff = -diff;
               if (diff > lim * den) return 1'b1;
            end
         end
         return 1'b0;
      end
      if (sx != 0 || sy != 0) begin
         // single row or column: linear between the two end pixels
         den = (sx != 0) ? dx : dy;
         n = (sx != 0) ? sx : sy;
         stride = (sx != 0) ? 1 : w;
         g1 = pixel_copy[0];
         g2 = pixel_copy[n * stride];
         for (int k = 0; k <= n; k++) begin
            xi = k;
            num = g1 * (den - xi) + g2 * xi;
            diff = 16 * num - 16 * longint'(pixel_copy[k * stride]) * den;
            if (diff < 0) diff = -diff;
            if (diff > lim * den) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic take_pixel();
      verdict_type verdict;
      int          area;
      if (pixels_seen == 0) begin
         block_span_x = req_span_x;
         block_span_y = req_span_y;
      end
      if (pixels_seen < bbht_pkg::STORE_DEPTH)
         pixel_copy[pixels_seen[bbht_pkg::ADDR_W-1:0]] = req_pixel;
      if (pixels_seen != bbht_pkg::COUNT_MAX) pixels_seen++;
      if (req_last) begin
         area = (int'(block_span_x) + 1) * (int'(block_span_y) + 1);
         verdict.count_error = (int'(pixels_seen) != area)
                            || (int'(block_span_x) >= bbht_pkg::BLOCK_SIDE)
                            || (int'(block_span_y) >= bbht_pkg::BLOCK_SIDE);
         // skip the scan on a count error: the store may hold stale entries
         verdict.needs_split = verdict.count_error ? 1'b0 : block_deviates();
         verdicts_due.push_back(verdict);
         pixels_seen = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type due;
      if (reset) begin
         pixels_seen = '0;
         block_span_x = '0;
         block_span_y = '0;
         allowed_dev = bbht_pkg::THRESHOLD_RESET;
         verdicts_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("result %b/%b with none due",
                  rsp_needs_split, rsp_count_error));
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_needs_split !== due.needs_split)
                  report_mismatch($sformatf("needs_split %b, predicted %b",
                     rsp_needs_split, due.needs_split));
               if (rsp_count_error !== due.count_error)
                  report_mismatch($sformatf("count_error %b, predicted %b",
                     rsp_count_error, due.count_error));
            end
         end
         if (csr_valid && csr_ready) allowed_dev = csr_threshold;
         if (req_valid && !req_stall) take_pixel();
      end
      verdicts_pending <= verdicts_due.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 35;

   typedef enum {FLOW_FREE, FLOW_COIN, FLOW_CHOKED, FLOW_PULSED} flow_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [bbht_pkg::PIX_W-1:0]  req_pixel = '0;
   logic [bbht_pkg::SPAN_W-1:0] req_span_x = '0;
   logic [bbht_pkg::SPAN_W-1:0] req_span_y = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_needs_split;
   logic                        rsp_count_error;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [bbht_pkg::THR_W-1:0]  csr_threshold = '0;

   int   mismatch_count;
   int   verdicts_pending;
   int   cycles = 0;
   int   burst_left = 0;
   int   gap_max = 4;
   int   items_sent = 0;
   int   corner_level [4];
   logic hold_off_request = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   bilinear_block_homogeneity_test dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_span_x      (req_span_x),
      .req_span_y      (req_span_y),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_needs_split (rsp_needs_split),
      .rsp_count_error (rsp_count_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_threshold   (csr_threshold)
   );

   bbht_scoreboard scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_span_x       (req_span_x),
      .req_span_y       (req_span_y),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_needs_split  (rsp_needs_split),
      .rsp_count_error  (rsp_count_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_threshold    (csr_threshold),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: stall pattern changes every window; a hold-off freezes it.
   initial begin : receiver
      flow_type flow;
      int       window;
      int       tick;
      flow = FLOW_FREE;
      window = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (window == 0) begin
            flow = flow_type'($urandom_range(0, 3));
            window = $urandom_range(16, 160);
         end
         window--;
         tick++;
         case (flow)
            FLOW_FREE:   rsp_stall = 1'b0;
            FLOW_COIN:   rsp_stall = 1'($urandom_range(0, 1));
            FLOW_CHOKED: rsp_stall = ($urandom_range(0, 3) != 0);
            default:     rsp_stall = (tick % 5) < 3;
         endcase
      end
   end

   task automatic send_pixel(input logic [bbht_pkg::PIX_W-1:0] pix,
                             input logic [bbht_pkg::SPAN_W-1:0] sx,
                             input logic [bbht_pkg::SPAN_W-1:0] sy,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid = 1'b1;
      req_pixel = pix;
      req_span_x = sx;
      req_span_y = sy;
      req_last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Smooth surface through the corner levels plus bounded noise.
   function automatic logic [bbht_pkg::PIX_W-1:0] shade(input int sx, input int sy,
                                                        input int x, input int y,
                                                        input int noise);
      int level;
      if (sx != 0 && sy != 0)
         level = (corner_level[0] * (sx - x) * (sy - y) + corner_level[1] * x * (sy - y)
                + corner_level[2] * (sx - x) * y + corner_level[3] * x * y) / (sx * sy);
      else if (sx != 0)
         level = (corner_level[0] * (sx - x) + corner_level[1] * x) / sx;
      else if (sy != 0)
         level = (corner_level[0] * (sy - y) + corner_level[2] * y) / sy;
      else
         level = corner_level[0];
      if (noise > 0) level += int'($urandom_range(0, 2 * noise)) - noise;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      return level[bbht_pkg::PIX_W-1:0];
   endfunction

   task automatic pick_corners();
      for (int c = 0; c < 4; c++) corner_level[c] = $urandom_range(0, 255);
   endtask

   task automatic send_block(input int sx, input int sy, input int count, input int noise);
      int                          w;
      logic [bbht_pkg::SPAN_W-1:0] gx, gy;
      w = sx + 1;
      for (int i = 0; i < count; i++) begin
         gx = bbht_pkg::SPAN_W'(sx);
         gy = bbht_pkg::SPAN_W'(sy);
         // spans after the first item must be ignored
         if (i != 0 && $urandom_range(0, 7) == 0) begin
            gx = bbht_pkg::SPAN_W'($urandom);
            gy = bbht_pkg::SPAN_W'($urandom);
         end
         send_pixel(shade(sx, sy, i % w, i / w, noise), gx, gy, i == count - 1);
      end
   endtask

   task automatic send_random_block();
      int kind, sx, sy, count, noise;
      kind = $urandom_range(0, 19);
      sx = $urandom_range(0, 7);
      sy = $urandom_range(0, 7);
      if (kind >= 17) begin
         sx = $urandom_range(0, 12);
         sy = $urandom_range(0, 12);
      end else if (kind >= 14) begin
         sy = 0;
      end else if (kind == 13) begin
         sx = 0;
      end
      count = (sx + 1) * (sy + 1);
      // broken blocks: too few or too many pixels
      if (kind < 3) begin
         if (count > 1 && $urandom_range(0, 1))
            count = count - int'($urandom_range(1, count - 1));
         else
            count = count + int'($urandom_range(1, 3));
      end
      case ($urandom_range(0, 4))
         0:       noise = 0;
         1:       noise = 3;
         2:       noise = 8;
         3:       noise = 15;
         default: noise = 255;
      endcase
      pick_corners();
      send_block(sx, sy, count, noise);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [bbht_pkg::THR_W-1:0] value);
      wait_idle();
      csr_valid = 1'b1;
      csr_threshold = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      int start;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // single pixels, an oversized span with one pixel, ramps, corners only
      send_pixel(8'h00, 6'd0, 6'd0, 1'b1);
      send_pixel(8'hFF, 6'd63, 6'd63, 1'b1);
      send_pixel(8'd0, 6'd2, 6'd0, 1'b0);
      send_pixel(8'd128, 6'd2, 6'd0, 1'b0);
      send_pixel(8'd255, 6'd2, 6'd0, 1'b1);
      send_pixel(8'd0, 6'd0, 6'd2, 1'b0);
      send_pixel(8'd255, 6'd0, 6'd2, 1'b0);
      send_pixel(8'd0, 6'd0, 6'd2, 1'b1);
      send_pixel(8'd10, 6'd1, 6'd1, 1'b0);
      send_pixel(8'd200, 6'd1, 6'd1, 1'b0);
      send_pixel(8'd30, 6'd1, 6'd1, 1'b0);
      send_pixel(8'd250, 6'd1, 6'd1, 1'b1);
      // flat 3x3 with a bright center; later items carry bogus spans
      for (int i = 0; i < 9; i++)
         send_pixel((i == 4) ? 8'd120 : 8'd100, (i == 0) ? 6'd2 : 6'd63,
                    (i == 0) ? 6'd2 : 6'd0, i == 8);
      // short block, then a long one
      send_pixel(8'd7, 6'd1, 6'd1, 1'b0);
      send_pixel(8'd9, 6'd1, 6'd1, 1'b1);
      send_pixel(8'd1, 6'd0, 6'd0, 1'b0);
      send_pixel(8'd2, 6'd0, 6'd0, 1'b0);
      send_pixel(8'd3, 6'd0, 6'd0, 1'b1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       ;
            1:       write_threshold('0);
            2:       write_threshold('1);
            3:       write_threshold(12'd1);
            4:       write_threshold(bbht_pkg::THR_W'($urandom_range(0, 4095)));
            5:       write_threshold(bbht_pkg::THRESHOLD_RESET);
            default: write_threshold(bbht_pkg::THR_W'($urandom_range(1, 400)));
         endcase
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 8);
         start = items_sent;
         if (phase == 3) begin
            // freeze the result side and keep feeding small blocks
            hold_off_request = 1'b1;
            for (int b = 0; b < 30; b++) begin
               pick_corners();
               send_block(1, 1, 4, 20);
            end
         end
         while (items_sent - start < PHASE_ITEMS) send_random_block();
         wait_idle();
      end

      // widest row and tallest column, then a small noisy block
      gap_max = 3;
      write_threshold(12'd32);
      pick_corners();
      send_block(63, 0, 64, 8);
      pick_corners();
      send_block(0, 63, 64, 8);
      pick_corners();
      send_block(2, 3, 12, 30);

      wait_idle();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
